// ----- sv/grid_cell_binner_3d_top_defines.svh -----
// Assertion macros shared by the grid cell binner RTL.
`ifndef GRID_CELL_BINNER_3D_TOP_DEFINES_SVH
`define GRID_CELL_BINNER_3D_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled in reset.
`define GCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled in reset.
`define GCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/gcb_pkg.sv -----
// Types, constants and helper functions for the grid cell binner.
`timescale 1ns / 1ps
package gcb_pkg;

  localparam int STEP_W       = 31;
  localparam int CELLS_W      = 5;
  localparam int ID_W         = 32;
  localparam int RANK_W       = 32;
  localparam int CELL_INDEX_W = 12;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 31;
  localparam int OUT_RAW_W    = CELL_INDEX_W + ID_W + RANK_W;
  localparam int OUT_W        = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_X     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_Z     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CELLS_X    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CELLS_Y    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CELLS_Z    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ORDER_MODE = 3'd6;

  localparam logic ORDER_X_FAST = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

  typedef struct packed {
    logic mul1;
    logic mul2;
  } merge_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Quotient bits needed before the slot is clamped to the cell count.
  function automatic int quo_bits(input int m);
    int lim;
    lim = (m < 31) ? m : 31;
    return idx_bits(lim);
  endfunction

endpackage

// ----- sv/gcb_axis_lane.sv -----
// One axis lane: sign check, restoring division a bit per cycle, clamp to slot.
`timescale 1ns / 1ps
module gcb_axis_lane #(
  parameter int POS_WIDTH         = 32,
  parameter int MAX_CELLS_PER_DIM = 16
) (
  input  logic                                                  clk,
  input  gcb_pkg::lane_ctl_t                                    ctl,
  input  logic [POS_WIDTH-1:0]                                  pos,
  input  logic [gcb_pkg::STEP_W-1:0]                            step_cfg,
  input  logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM+1)-1:0]     eff,
  output logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM)-1:0]       slot
);
  import gcb_pkg::*;

  localparam int QB  = quo_bits(MAX_CELLS_PER_DIM);
  localparam int EW  = idx_bits(MAX_CELLS_PER_DIM + 1);
  localparam int SW  = idx_bits(MAX_CELLS_PER_DIM);
  localparam int XW  = EW + QB;
  localparam int CW  = ((POS_WIDTH > STEP_W + QB) ? POS_WIDTH : STEP_W + QB) + 1;

  logic          neg;
  logic          sat;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic [QB-1:0] quo;
  logic          ge;

  assign ge = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg <= pos[POS_WIDTH-1];
      sat <= (CW'(pos[POS_WIDTH-2:0]) >= (CW'(step_cfg) << QB));
      rem <= CW'(pos[POS_WIDTH-2:0]);
      dvs <= CW'(step_cfg) << (QB - 1);
      quo <= '0;
    end else if (ctl.step) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      quo <= QB'({quo, ge});
      dvs <= dvs >> 1;
    end
  end

  always_comb begin
    if (neg) begin
      slot = '0;
    end else if (sat || (XW'(quo) >= XW'(eff))) begin
      slot = SW'(eff - 1'b1);
    end else begin
      slot = SW'(quo);
    end
  end

endmodule

// ----- sv/gcb_merge.sv -----
// Merge stage: combine the three axis slots into a linear cell index.
`timescale 1ns / 1ps
module gcb_merge #(
  parameter int MAX_CELLS_PER_DIM = 16
) (
  input  logic                                                        clk,
  input  gcb_pkg::merge_ctl_t                                         ctl,
  input  logic                                                        order_mode,
  input  logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM)-1:0]             sx,
  input  logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM)-1:0]             sy,
  input  logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM)-1:0]             sz,
  input  logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM+1)-1:0]           nx,
  input  logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM+1)-1:0]           ny,
  input  logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM+1)-1:0]           nz,
  output logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM**3)-1:0]          idx
);
  import gcb_pkg::*;

  localparam int SW  = idx_bits(MAX_CELLS_PER_DIM);
  localparam int EW  = idx_bits(MAX_CELLS_PER_DIM + 1);
  localparam int T1W = idx_bits(MAX_CELLS_PER_DIM * MAX_CELLS_PER_DIM);
  localparam int IW  = idx_bits(MAX_CELLS_PER_DIM ** 3);

  logic [T1W-1:0] t1;
  logic [SW-1:0]  outer;
  logic [SW-1:0]  inner;
  logic [EW-1:0]  inner_n;

  always_comb begin
    if (order_mode == ORDER_X_FAST) begin
      outer   = sz;
      inner   = sx;
      inner_n = nx;
    end else begin
      outer   = sx;
      inner   = sz;
      inner_n = nz;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      t1 <= T1W'(T1W'(outer) * T1W'(ny) + T1W'(sy));
    end
    if (ctl.mul2) begin
      idx <= IW'(IW'(t1) * IW'(inner_n) + IW'(inner));
    end
  end

endmodule

// ----- sv/gcb_count_store.sv -----
// Per-cell counter memory with read-modify-write and a clearing pass after reset.
`timescale 1ns / 1ps
module gcb_count_store #(
  parameter int MAX_CELLS_PER_DIM = 16
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  gcb_pkg::store_ctl_t                                 ctl,
  input  logic [gcb_pkg::idx_bits(MAX_CELLS_PER_DIM**3)-1:0]  addr,
  output logic [gcb_pkg::RANK_W-1:0]                          rank,
  output logic                                                busy
);
  import gcb_pkg::*;

  localparam int DEPTH = MAX_CELLS_PER_DIM ** 3;
  localparam int IW    = idx_bits(DEPTH);

  logic [RANK_W-1:0] mem [DEPTH];
  logic [RANK_W-1:0] rd_data;
  logic [IW-1:0]     clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr_en) begin
      mem[addr] <= (rd_data == '1) ? rd_data : rd_data + 1'b1;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign rank = rd_data;

endmodule

// ----- sv/grid_cell_binner_3d_top.sv -----
// Top level of the 3D uniform grid cell binner.
// Each accepted particle steps through DIV (bit-serial axis division, QB = quotient bits, 4 at 16 cells),
// MUL1 and MUL2 (two-step index multiply), then READ and WRITE (counter read-modify-write).
// WRITE waits while an earlier result is unaccepted; a new particle is taken only back in IDLE.
// Reset (rst, synchronous): registers to defaults, then a clearing pass over all
// MAX_CELLS_PER_DIM**3 counters (4096) with s_tready low.
`timescale 1ns / 1ps
`include "grid_cell_binner_3d_top_defines.svh"
module grid_cell_binner_3d_top #(
  parameter int MAX_CELLS_PER_DIM = 16,
  parameter int POS_WIDTH         = 32
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    s_tvalid,
  output logic                                                    s_tready,
  // pos_x, pos_y, pos_z, particle_id
  input  logic [((3*POS_WIDTH+gcb_pkg::ID_W+7)/8)*8-1:0]          s_tdata,
  output logic                                                    m_tvalid,
  input  logic                                                    m_tready,
  // cell_index, id_out, rank_in_cell
  output logic [gcb_pkg::OUT_W-1:0]                               m_tdata,
  input  logic                                                    cfg_valid,
  output logic                                                    cfg_ready,
  input  logic [gcb_pkg::CFG_INDEX_W-1:0]                         cfg_index,
  input  logic [gcb_pkg::CFG_DATA_W-1:0]                          cfg_data
);
  import gcb_pkg::*;

  localparam int QB   = quo_bits(MAX_CELLS_PER_DIM);
  localparam int CNTW = idx_bits(QB);
  localparam int EW   = idx_bits(MAX_CELLS_PER_DIM + 1);
  localparam int SW   = idx_bits(MAX_CELLS_PER_DIM);
  localparam int IW   = idx_bits(MAX_CELLS_PER_DIM ** 3);

  logic [STEP_W-1:0]  step_x;
  logic [STEP_W-1:0]  step_y;
  logic [STEP_W-1:0]  step_z;
  logic [CELLS_W-1:0] cells_x;
  logic [CELLS_W-1:0] cells_y;
  logic [CELLS_W-1:0] cells_z;
  logic               order_mode;

  logic [EW-1:0]      nx;
  logic [EW-1:0]      ny;
  logic [EW-1:0]      nz;
  logic [SW-1:0]      sx;
  logic [SW-1:0]      sy;
  logic [SW-1:0]      sz;
  logic [IW-1:0]      idx;
  logic [RANK_W-1:0]  rank;
  logic [ID_W-1:0]    id_hold;
  logic               store_busy;

  state_t             state;
  state_t             state_next;
  logic [CNTW-1:0]    cnt;
  lane_ctl_t          lane_ctl;
  merge_ctl_t         merge_ctl;
  store_ctl_t         store_ctl;

  function automatic logic [EW-1:0] eff_of(input logic [CELLS_W-1:0] n);
    if (n == '0) begin
      return EW'(1);
    end else if (int'(n) > MAX_CELLS_PER_DIM) begin
      return EW'(MAX_CELLS_PER_DIM);
    end else begin
      return EW'(n);
    end
  endfunction

  assign nx = eff_of(cells_x);
  assign ny = eff_of(cells_y);
  assign nz = eff_of(cells_z);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x     <= STEP_W'(65536);
      step_y     <= STEP_W'(65536);
      step_z     <= STEP_W'(65536);
      cells_x    <= CELLS_W'(1);
      cells_y    <= CELLS_W'(1);
      cells_z    <= CELLS_W'(1);
      order_mode <= ORDER_X_FAST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_X:     step_x     <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:     step_y     <= cfg_data[STEP_W-1:0];
        REG_STEP_Z:     step_z     <= cfg_data[STEP_W-1:0];
        REG_CELLS_X:    cells_x    <= cfg_data[CELLS_W-1:0];
        REG_CELLS_Y:    cells_y    <= cfg_data[CELLS_W-1:0];
        REG_CELLS_Z:    cells_z    <= cfg_data[CELLS_W-1:0];
        REG_ORDER_MODE: order_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gcb_axis_lane #(.POS_WIDTH(POS_WIDTH), .MAX_CELLS_PER_DIM(MAX_CELLS_PER_DIM)) u_lane_x (
    .clk      (clk),
    .ctl      (lane_ctl),
    .pos      (s_tdata[POS_WIDTH-1:0]),
    .step_cfg (step_x),
    .eff      (nx),
    .slot     (sx)
  );

  gcb_axis_lane #(.POS_WIDTH(POS_WIDTH), .MAX_CELLS_PER_DIM(MAX_CELLS_PER_DIM)) u_lane_y (
    .clk      (clk),
    .ctl      (lane_ctl),
    .pos      (s_tdata[2*POS_WIDTH-1:POS_WIDTH]),
    .step_cfg (step_y),
    .eff      (ny),
    .slot     (sy)
  );

  gcb_axis_lane #(.POS_WIDTH(POS_WIDTH), .MAX_CELLS_PER_DIM(MAX_CELLS_PER_DIM)) u_lane_z (
    .clk      (clk),
    .ctl      (lane_ctl),
    .pos      (s_tdata[3*POS_WIDTH-1:2*POS_WIDTH]),
    .step_cfg (step_z),
    .eff      (nz),
    .slot     (sz)
  );

  gcb_merge #(.MAX_CELLS_PER_DIM(MAX_CELLS_PER_DIM)) u_merge (
    .clk        (clk),
    .ctl        (merge_ctl),
    .order_mode (order_mode),
    .sx         (sx),
    .sy         (sy),
    .sz         (sz),
    .nx         (nx),
    .ny         (ny),
    .nz         (nz),
    .idx        (idx)
  );

  gcb_count_store #(.MAX_CELLS_PER_DIM(MAX_CELLS_PER_DIM)) u_store (
    .clk  (clk),
    .rst  (rst),
    .ctl  (store_ctl),
    .addr (idx),
    .rank (rank),
    .busy (store_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    lane_ctl   = '0;
    merge_ctl  = '0;
    store_ctl  = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !store_busy;
        if (s_tvalid && !store_busy) begin
          lane_ctl.load = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        lane_ctl.step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        merge_ctl.mul1 = 1'b1;
        state_next     = ST_MUL2;
      end
      ST_MUL2: begin
        merge_ctl.mul2 = 1'b1;
        state_next     = ST_READ;
      end
      ST_READ: begin
        store_ctl.rd_en = 1'b1;
        state_next      = ST_WRITE;
      end
      ST_WRITE: begin
        if (!m_tvalid || m_tready) begin
          store_ctl.wr_en = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lane_ctl.load) begin
      cnt     <= CNTW'(QB - 1);
      id_hold <= s_tdata[3*POS_WIDTH+ID_W-1:3*POS_WIDTH];
    end else if (lane_ctl.step) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (store_ctl.wr_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (store_ctl.wr_en) begin
      m_tdata <= OUT_W'({rank, id_hold, CELL_INDEX_W'(idx)});
    end
  end

  `GCB_ASSERT_NXT(a_accept_starts_div, s_tvalid && s_tready, state == ST_DIV, "accept did not start division")
  `GCB_ASSERT_NXT(a_write_loads_out, store_ctl.wr_en, m_tvalid, "counter update without result")
  `GCB_ASSERT_NXT(a_read_then_write, store_ctl.rd_en, state == ST_WRITE, "counter read not followed by write")
  `GCB_ASSERT_IMP(a_clear_holds_idle, store_busy, state == ST_IDLE, "item in flight during clearing pass")

endmodule

// ----- tb/tb_grid_cell_binner_3d_top.sv -----
// Self-checking testbench for the 3D grid cell binner: predicted cell, ID and rank per particle.
`timescale 1ns / 1ps
module tb_grid_cell_binner_3d_top;
  import gcb_pkg::*;

  localparam int IN_W        = 128;
  localparam int GRID_MAX    = 16;
  localparam int STORE_DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 38;
  localparam int RAND_PHASES = 11;
  localparam int PHASE_ITEMS = 104;

  typedef struct {
    logic [CELL_INDEX_W-1:0] cell_idx;
    logic [ID_W-1:0]         id;
    logic [RANK_W-1:0]       rank;
  } bin_t;

  class cell_rank_tracker;
    logic [STEP_W-1:0]  pitch [3];
    logic [CELLS_W-1:0] cells [3];
    logic               order_mode;
    logic [RANK_W-1:0]  counts [STORE_DEPTH];
    bin_t               pending_bins [$];
    int                 errors;
    int                 checked;

    function new();
      for (int i = 0; i < 3; i++) begin
        pitch[i] = 31'd65536;
        cells[i] = 5'd1;
      end
      order_mode = ORDER_X_FAST;
      for (int i = 0; i < STORE_DEPTH; i++) counts[i] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_STEP_X:     pitch[0] = value;
        REG_STEP_Y:     pitch[1] = value;
        REG_STEP_Z:     pitch[2] = value;
        REG_CELLS_X:    cells[0] = value[CELLS_W-1:0];
        REG_CELLS_Y:    cells[1] = value[CELLS_W-1:0];
        REG_CELLS_Z:    cells[2] = value[CELLS_W-1:0];
        REG_ORDER_MODE: order_mode = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned grid_size(logic [CELLS_W-1:0] n);
      if (n == 0) return 1;
      if (n > GRID_MAX) return GRID_MAX;
      return n;
    endfunction

    function int unsigned axis_slot(logic [31:0] pos, logic [STEP_W-1:0] stp, int unsigned n);
      int unsigned q;
      if (pos[31]) return 0;
      if (stp == 0) return n - 1;
      q = pos / {1'b0, stp};
      return (q >= n) ? n - 1 : q;
    endfunction

    function void note_particle(logic [IN_W-1:0] beat);
      int unsigned n [3];
      int unsigned s [3];
      int unsigned idx;
      bin_t        b;
      for (int i = 0; i < 3; i++) begin
        n[i] = grid_size(cells[i]);
        s[i] = axis_slot(beat[32*i +: 32], pitch[i], n[i]);
      end
      if (order_mode == ORDER_X_FAST) idx = (s[2] * n[1] + s[1]) * n[0] + s[0];
      else idx = (s[0] * n[1] + s[1]) * n[2] + s[2];
      b.cell_idx = idx[CELL_INDEX_W-1:0];
      b.id       = beat[127:96];
      b.rank     = counts[idx];
      if (counts[idx] != 32'hFFFF_FFFF) counts[idx] = counts[idx] + 1;
      pending_bins.push_back(b);
    endfunction

    function void check_bin(logic [OUT_W-1:0] beat);
      bin_t want;
      checked++;
      if (pending_bins.size() == 0) begin
        $display("%0t: result with nothing expected, beat %h", $time, beat);
        errors++;
        return;
      end
      want = pending_bins.pop_front();
      if (beat[11:0] !== want.cell_idx) begin
        $display("%0t: cell_index expected %0d actual %0d", $time, want.cell_idx, beat[11:0]);
        errors++;
      end
      if (beat[43:12] !== want.id) begin
        $display("%0t: id_out expected %h actual %h", $time, want.id, beat[43:12]);
        errors++;
      end
      if (beat[75:44] !== want.rank) begin
        $display("%0t: rank_in_cell expected %0d actual %0d", $time, want.rank, beat[75:44]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_W-1:0]       m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cell_rank_tracker   tracker;
  int                 cycle_count;
  int                 particles_sent;
  int                 settings_applied;
  int                 held_cycles;
  logic [STEP_W-1:0]  cur_pitch [3];
  logic [CELLS_W-1:0] cur_cells [3];

  grid_cell_binner_3d_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_grid_cell_binner_3d_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_bin(m_tdata);
  end

  // Output side: random stalls, one long hold-off, and a stretch with no stalls.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
        held_cycles++;
      end else if (!hold_done && tracker.checked >= 180) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES - 1;
        held_cycles++;
        m_tready  = 1'b0;
      end else if (tracker.checked >= 600 && tracker.checked < 760) begin
        m_tready = 1'b1;
      end else begin
        m_tready = ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic offer_particle(input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] pz, input logic [31:0] pid);
    while (!(particles_sent >= 600 && particles_sent < 760) &&
           $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {pid, pz, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_particle(s_tdata);
    particles_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(index, value);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (tracker.pending_bins.size() != 0) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [STEP_W-1:0] px, input logic [STEP_W-1:0] py,
                                input logic [STEP_W-1:0] pz, input logic [CELLS_W-1:0] nx,
                                input logic [CELLS_W-1:0] ny, input logic [CELLS_W-1:0] nz,
                                input logic order_z);
    wait_drained();
    write_reg(REG_STEP_X, px);
    write_reg(REG_STEP_Y, py);
    write_reg(REG_STEP_Z, pz);
    write_reg(REG_CELLS_X, CFG_DATA_W'(nx));
    write_reg(REG_CELLS_Y, CFG_DATA_W'(ny));
    write_reg(REG_CELLS_Z, CFG_DATA_W'(nz));
    write_reg(REG_ORDER_MODE, CFG_DATA_W'(order_z));
    cfg_valid = 1'b0;
    cur_pitch = '{px, py, pz};
    cur_cells = '{nx, ny, nz};
    settings_applied++;
  endtask

  // Mostly positions spread over the grid and just past it; the rest negative or raw.
  function automatic logic [31:0] pick_pos(input logic [STEP_W-1:0] stp,
                                           input logic [CELLS_W-1:0] nc);
    int unsigned r;
    int unsigned n;
    longint      v;
    r = $urandom_range(0, 99);
    n = (nc == 0) ? 1 : ((nc > GRID_MAX) ? GRID_MAX : nc);
    if (r < 15) return $urandom | 32'h8000_0000;
    if (r < 30 || stp == 0) return $urandom;
    v = longint'($urandom_range(0, n)) * longint'(stp) +
        longint'($urandom_range(0, stp - 1));
    if (v > 64'sh7FFF_FFFF) return $urandom & 32'h7FFF_FFFF;
    return v[31:0];
  endfunction

  task automatic random_settings();
    logic [STEP_W-1:0]  p [3];
    logic [CELLS_W-1:0] c [3];
    int unsigned        r;
    for (int i = 0; i < 3; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) c[i] = 5'd0;
      else if (r < 16) c[i] = CELLS_W'($urandom_range(17, 31));
      else if (r < 55) c[i] = CELLS_W'($urandom_range(1, 4));
      else c[i] = CELLS_W'($urandom_range(1, 16));
      r = $urandom_range(0, 99);
      if (r < 5) p[i] = '0;
      else if (r < 30) p[i] = STEP_W'($urandom_range(1, 64));
      else if (r < 70) p[i] = STEP_W'($urandom_range(32'h4000, 32'h4_0000));
      else p[i] = STEP_W'($urandom_range(32'h10_0000, 32'h7FFF_FFFF));
    end
    apply_settings(p[0], p[1], p[2], c[0], c[1], c[2], 1'($urandom_range(0, 1)));
  endtask

  initial begin
    tracker          = new();
    cycle_count      = 0;
    particles_sent   = 0;
    settings_applied = 0;
    held_cycles      = 0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_pitch = '{31'd65536, 31'd65536, 31'd65536};
    cur_cells = '{5'd1, 5'd1, 5'd1};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: single cell, extremes of every field
    offer_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    offer_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    offer_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678);
    offer_particle(32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0000, 32'hA5A5_A5A5);

    // full grid, narrowest and widest cells, x fastest
    apply_settings(31'd1, 31'h7FFF_FFFF, 31'd65536, 5'd16, 5'd16, 5'd16, ORDER_X_FAST);
    offer_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd1);
    offer_particle(32'd15, 32'h7FFF_FFFE, 32'h000F_0000, 32'd2);
    offer_particle(32'd16, 32'h7FFF_FFFF, 32'h0010_0000, 32'd3);
    offer_particle(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd4);
    offer_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd5);
    offer_particle(32'd3, 32'd0, 32'h0002_8000, 32'd6);
    offer_particle(32'd3, 32'd0, 32'h0002_8000, 32'd7);

    // zero step on x, zero and oversized cell counts, z fastest
    apply_settings(31'd0, 31'd65536, 31'd3, 5'd16, 5'd0, 5'd31, ~ORDER_X_FAST);
    offer_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd8);
    offer_particle(32'h8000_0000, 32'h0005_0000, 32'd47, 32'd9);
    offer_particle(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd2, 32'd10);
    offer_particle(32'd1, 32'd0, 32'h8000_0000, 32'd11);
    offer_particle(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    offer_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_settings();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        offer_particle(pick_pos(cur_pitch[0], cur_cells[0]),
                       pick_pos(cur_pitch[1], cur_cells[1]),
                       pick_pos(cur_pitch[2], cur_cells[2]), $urandom);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("binned %0d particles under %0d grid settings, %0d results checked",
             particles_sent, settings_applied, tracker.checked);
    $display("output held off for %0d cycles in one stretch; %0d mismatches",
             held_cycles, tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb_grid_cell_binner_3d_top: done, clean");
    end else begin
      $display("tb_grid_cell_binner_3d_top: done, errors");
    end
    $finish;
  end
endmodule
